@@ sv/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants and types for the textbook RSA key derivation and
// modular exponentiation block.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // default factor width
    localparam int FACTOR_BITS = 16;

    // configuration register indexes
    localparam int          CFG_IDX_W = 8;
    localparam logic [7:0]  CFG_FACTOR_P = 8'd0;
    localparam logic [7:0]  CFG_FACTOR_Q = 8'd1;

    // reset values of the factors
    localparam int RESET_P = 7;
    localparam int RESET_Q = 13;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_PROD,
        S_GCD_START,
        S_GCD_W,
        S_INV,
        S_INV_DW,
        S_INV_MW,
        S_CHECK,
        S_BASE_W,
        S_EXP,
        S_MR_W,
        S_SQ,
        S_SQ_W,
        S_DONE
    } t_state;

endpackage

@@ sv/rsa_mulmod.sv @@
// ----------------------------------------------------------------------------
// rsa_mulmod
// Bit-serial modular multiplier: res = a*b mod m, one bit of b per cycle,
// most significant bit first. Requires a < m.
// ----------------------------------------------------------------------------
module rsa_mulmod #(
    parameter int MW = 32,
    parameter int BW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    input  logic [MW-1:0] i_m,
    output logic          o_done,
    output logic [MW-1:0] o_res
);
    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW-1:0] r_a, n_a;
    logic [MW-1:0] r_m, n_m;
    logic [BW-1:0] r_b, n_b;
    logic [MW-1:0] r_r, n_r;
    logic [MW-1:0] w_dbl;
    logic [MW-1:0] w_add;
    logic [MW-1:0] w_room_r;
    logic [MW-1:0] w_room_a;

    // double, then add a when the current bit is set
    always_comb begin
        w_room_r = r_m - r_r;
        w_dbl    = (r_r >= w_room_r) ? (r_r - w_room_r) : (r_r + r_r);
        w_room_a = r_m - r_a;
        w_add    = (w_dbl >= w_room_a) ? (w_dbl - w_room_a) : (w_dbl + r_a);
    end

    // advance one bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_m    = r_m;
        n_b    = r_b;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(BW - 1);
            n_a    = i_a;
            n_m    = i_m;
            n_b    = i_b;
            n_r    = '0;
        end else if (r_busy) begin
            n_r = r_b[BW-1] ? w_add : w_dbl;
            n_b = r_b << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_m   <= n_m;
        r_b   <= n_b;
        r_r   <= n_r;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

@@ sv/rsa_div.sv @@
// ----------------------------------------------------------------------------
// rsa_div
// Restoring divider, one quotient bit per cycle: quotient and remainder of
// an unsigned dividend by a nonzero divisor.
// ----------------------------------------------------------------------------
module rsa_div #(
    parameter int MW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    output logic          o_done,
    output logic [MW-1:0] o_quo,
    output logic [MW-1:0] o_rem
);
    localparam int CW = (MW > 1) ? $clog2(MW) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW-1:0] r_den, n_den;
    logic [MW-1:0] r_quo, n_quo;
    logic [MW-1:0] r_rem, n_rem;
    logic [MW:0]   w_trial;
    logic          w_fit;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        w_trial = {r_rem, r_quo[MW-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(MW - 1);
            n_den  = i_den;
            n_quo  = i_num;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_fit ? MW'(w_trial - {1'b0, r_den}) : MW'(w_trial);
            n_quo = {r_quo[MW-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_den <= n_den;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ sv/rsa_keygen_and_modexp.sv @@
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp
// Textbook RSA: derives n, phi, e and d from two factors and raises each
// input value to e or d modulo n by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Work per item: one reduction of the value modulo n, one product per set
//   exponent bit and one square per bit below the top, all on the shared
//   bit-serial multiplier.
// Key derivation after reset or a factor write adds a shift-and-add loop for n
//   and phi, one divide per gcd step, a divide and a product per inverse step.
// Throughput: one item at a time. Reset clears the keys and restores the factors.
module rsa_keygen_and_modexp #(
    parameter int FACTOR_BITS = rsa_pkg::FACTOR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FACTOR_BITS-1:0]         i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic [31:0]                    i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [31:0]                    o_result,
    output logic [31:0]                    o_public_exponent,
    output logic [31:0]                    o_modulus,
    output logic                           o_key_error
);
    localparam int FB = FACTOR_BITS;
    localparam int MW = 2 * FACTOR_BITS;
    localparam int BW = (MW > 32) ? MW : 32;
    localparam int FCW = $clog2(FB);

    rsa_pkg::t_state r_state, n_state;

    logic [FB-1:0]  r_fp, n_fp;
    logic [FB-1:0]  r_fq, n_fq;
    logic           r_keys_ready, n_keys_ready;
    logic [MW-1:0]  r_n, n_n;
    logic [MW-1:0]  r_phi, n_phi;
    logic [MW-1:0]  r_e, n_e;
    logic [MW-1:0]  r_d, n_d;
    logic           r_op, n_op;
    logic [31:0]    r_val, n_val;
    logic [MW-1:0]  r_pa, n_pa;
    logic [MW-1:0]  r_pm, n_pm;
    logic [FB-1:0]  r_qa, n_qa;
    logic [FB-1:0]  r_qm, n_qm;
    logic [FCW-1:0] r_cnt, n_cnt;
    logic [MW-1:0]  r_i, n_i;
    logic [MW-1:0]  r_ga, n_ga;
    logic [MW-1:0]  r_gb, n_gb;
    logic [MW-1:0]  r_t0, n_t0;
    logic [MW-1:0]  r_t1, n_t1;
    logic [MW-1:0]  r_rn, n_rn;
    logic [MW-1:0]  r_base, n_base;
    logic [MW-1:0]  r_acc, n_acc;
    logic [MW-1:0]  r_ex, n_ex;
    logic           r_ovalid, n_ovalid;
    logic [31:0]    r_ores, n_ores;
    logic [31:0]    r_opub, n_opub;
    logic [31:0]    r_omod, n_omod;
    logic           r_oerr, n_oerr;

    logic           w_mul_start;
    logic [MW-1:0]  w_mul_a;
    logic [BW-1:0]  w_mul_b;
    logic [MW-1:0]  w_mul_m;
    logic           w_mul_done;
    logic [MW-1:0]  w_mul_res;
    logic           w_div_start;
    logic [MW-1:0]  w_div_num;
    logic [MW-1:0]  w_div_den;
    logic           w_div_done;
    logic [MW-1:0]  w_div_quo;
    logic [MW-1:0]  w_div_rem;
    logic           w_accept;
    logic           w_cfg_xfer;
    logic [MW-1:0]  w_i_next;

    assign o_ready     = (r_state == rsa_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_cfg_xfer  = i_cfg_valid;
    assign w_i_next    = r_i + 1'b1;

    rsa_mulmod #(.MW(MW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_m     (w_mul_m),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    rsa_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rsa_pkg::S_IDLE;
            r_fp         <= FB'(rsa_pkg::RESET_P);
            r_fq         <= FB'(rsa_pkg::RESET_Q);
            r_keys_ready <= 1'b0;
            r_n          <= '0;
            r_phi        <= '0;
            r_e          <= '0;
            r_d          <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fp         <= n_fp;
            r_fq         <= n_fq;
            r_keys_ready <= n_keys_ready;
            r_n          <= n_n;
            r_phi        <= n_phi;
            r_e          <= n_e;
            r_d          <= n_d;
            r_ovalid     <= n_ovalid;
        end
        r_op   <= n_op;
        r_val  <= n_val;
        r_pa   <= n_pa;
        r_pm   <= n_pm;
        r_qa   <= n_qa;
        r_qm   <= n_qm;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_ga   <= n_ga;
        r_gb   <= n_gb;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_rn   <= n_rn;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_ex   <= n_ex;
        r_ores <= n_ores;
        r_opub <= n_opub;
        r_omod <= n_omod;
        r_oerr <= n_oerr;
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_fp         = r_fp;
        n_fq         = r_fq;
        n_keys_ready = r_keys_ready;
        n_n          = r_n;
        n_phi        = r_phi;
        n_e          = r_e;
        n_d          = r_d;
        n_op         = r_op;
        n_val        = r_val;
        n_pa         = r_pa;
        n_pm         = r_pm;
        n_qa         = r_qa;
        n_qm         = r_qm;
        n_cnt        = r_cnt;
        n_i          = r_i;
        n_ga         = r_ga;
        n_gb         = r_gb;
        n_t0         = r_t0;
        n_t1         = r_t1;
        n_rn         = r_rn;
        n_base       = r_base;
        n_acc        = r_acc;
        n_ex         = r_ex;
        n_ovalid     = r_ovalid && !i_ready;
        n_ores       = r_ores;
        n_opub       = r_opub;
        n_omod       = r_omod;
        n_oerr       = r_oerr;
        w_mul_start  = 1'b0;
        w_mul_a      = r_acc;
        w_mul_b      = BW'(r_base);
        w_mul_m      = r_n;
        w_div_start  = 1'b0;
        w_div_num    = r_gb;
        w_div_den    = r_ga;

        // factor writes drop the cached keys
        if (w_cfg_xfer) begin
            if (i_cfg_index == rsa_pkg::CFG_FACTOR_P) begin
                n_fp         = i_cfg_data;
                n_keys_ready = 1'b0;
            end else if (i_cfg_index == rsa_pkg::CFG_FACTOR_Q) begin
                n_fq         = i_cfg_data;
                n_keys_ready = 1'b0;
            end
        end

        case (r_state)
            rsa_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_opcode;
                    n_val = i_value;
                    if (r_keys_ready) begin
                        n_state = rsa_pkg::S_CHECK;
                    end else begin
                        n_pa    = MW'(r_fp);
                        n_pm    = MW'((r_fp != '0) ? (r_fp - 1'b1) : '0);
                        n_qa    = r_fq;
                        n_qm    = (r_fq != '0) ? (r_fq - 1'b1) : '0;
                        n_n     = '0;
                        n_phi   = '0;
                        n_cnt   = FCW'(FB - 1);
                        n_state = rsa_pkg::S_PROD;
                    end
                end
            end
            // shift-and-add for n and phi together
            rsa_pkg::S_PROD: begin
                if (r_qa[0]) n_n = r_n + r_pa;
                if (r_qm[0]) n_phi = r_phi + r_pm;
                n_pa  = r_pa << 1;
                n_pm  = r_pm << 1;
                n_qa  = r_qa >> 1;
                n_qm  = r_qm >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_e = '0;
                    n_d = '0;
                    n_i = MW'(2);
                    if (n_phi > MW'(2)) begin
                        n_state = rsa_pkg::S_GCD_START;
                    end else begin
                        n_keys_ready = 1'b1;
                        n_state      = rsa_pkg::S_CHECK;
                    end
                end
            end
            // gcd(i, phi) by Euclid
            rsa_pkg::S_GCD_START: begin
                n_ga    = r_i;
                n_gb    = r_phi;
                n_state = rsa_pkg::S_GCD_W;
                w_div_start = 1'b1;
                w_div_num   = r_phi;
                w_div_den   = r_i;
            end
            rsa_pkg::S_GCD_W: begin
                if (w_div_done) begin
                    n_gb = r_ga;
                    n_ga = w_div_rem;
                    if (w_div_rem != '0) begin
                        w_div_start = 1'b1;
                        w_div_num   = r_ga;
                        w_div_den   = w_div_rem;
                    end else if (r_ga == MW'(1)) begin
                        n_e     = r_i;
                        n_gb    = r_phi;
                        n_ga    = r_i;
                        n_t0    = '0;
                        n_t1    = MW'(1);
                        n_state = rsa_pkg::S_INV;
                    end else begin
                        n_i = w_i_next;
                        if (w_i_next < r_phi) begin
                            n_state = rsa_pkg::S_GCD_START;
                        end else begin
                            n_keys_ready = 1'b1;
                            n_state      = rsa_pkg::S_CHECK;
                        end
                    end
                end
            end
            // extended Euclid: r0 in ga/gb pair, coefficients in t0/t1
            rsa_pkg::S_INV: begin
                if (r_ga == '0) begin
                    n_d          = r_t0;
                    n_keys_ready = 1'b1;
                    n_state      = rsa_pkg::S_CHECK;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = r_gb;
                    w_div_den   = r_ga;
                    n_state     = rsa_pkg::S_INV_DW;
                end
            end
            rsa_pkg::S_INV_DW: begin
                w_mul_a = w_div_quo;
                w_mul_b = BW'(r_t1);
                w_mul_m = r_phi;
                if (w_div_done) begin
                    n_rn        = w_div_rem;
                    w_mul_start = 1'b1;
                    n_state     = rsa_pkg::S_INV_MW;
                end
            end
            rsa_pkg::S_INV_MW: begin
                if (w_mul_done) begin
                    n_t1 = (r_t0 >= w_mul_res) ? (r_t0 - w_mul_res)
                                               : (r_t0 + (r_phi - w_mul_res));
                    n_t0    = r_t1;
                    n_gb    = r_ga;
                    n_ga    = r_rn;
                    n_state = rsa_pkg::S_INV;
                end
            end
            // reduce the value modulo n, or report a missing key
            rsa_pkg::S_CHECK: begin
                w_mul_a = MW'(1);
                w_mul_b = BW'(r_val);
                if (r_e == '0) begin
                    n_acc   = '0;
                    n_state = rsa_pkg::S_DONE;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = rsa_pkg::S_BASE_W;
                end
            end
            rsa_pkg::S_BASE_W: begin
                if (w_mul_done) begin
                    n_base  = w_mul_res;
                    n_acc   = MW'(1);
                    n_ex    = r_op ? r_d : r_e;
                    n_state = rsa_pkg::S_EXP;
                end
            end
            // square-and-multiply, least significant exponent bit first
            rsa_pkg::S_EXP: begin
                if (r_ex == '0) begin
                    n_state = rsa_pkg::S_DONE;
                end else if (r_ex[0]) begin
                    w_mul_start = 1'b1;
                    n_state     = rsa_pkg::S_MR_W;
                end else begin
                    n_state = rsa_pkg::S_SQ;
                end
            end
            rsa_pkg::S_MR_W: begin
                if (w_mul_done) begin
                    n_acc   = w_mul_res;
                    n_state = rsa_pkg::S_SQ;
                end
            end
            rsa_pkg::S_SQ: begin
                w_mul_a = r_base;
                n_ex    = r_ex >> 1;
                if ((r_ex >> 1) == '0) begin
                    n_state = rsa_pkg::S_EXP;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = rsa_pkg::S_SQ_W;
                end
            end
            rsa_pkg::S_SQ_W: begin
                if (w_mul_done) begin
                    n_base  = w_mul_res;
                    n_state = rsa_pkg::S_EXP;
                end
            end
            // hold until the output register is free
            rsa_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ores   = 32'(r_acc);
                    n_opub   = 32'(r_e);
                    n_omod   = 32'(r_n);
                    n_oerr   = (r_e == '0);
                    n_state  = rsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_result          = r_ores;
    assign o_public_exponent = r_opub;
    assign o_modulus         = r_omod;
    assign o_key_error       = r_oerr;

    // a missing key always gives a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_error) |-> (o_result == 32'd0))
        else $error("key error with nonzero result");

    // multiplier results arrive only in states that wait for them
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == rsa_pkg::S_INV_MW || r_state == rsa_pkg::S_BASE_W
                        || r_state == rsa_pkg::S_MR_W || r_state == rsa_pkg::S_SQ_W))
        else $error("unexpected multiplier result");

    // a derived public exponent lies below phi
    a_e_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_keys_ready && r_e != '0) |-> (r_e < r_phi))
        else $error("public exponent out of range");

    // an accepted item leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != rsa_pkg::S_IDLE))
        else $error("accepted item did not start");

endmodule
